// ----- sv/b255c_pkg.sv -----
// shared types and constants for the base-255 chunk codec
package b255c_pkg;

  // powers of 255, index i holds 255^i
  localparam logic [3:0][31:0] POW255 = {32'd16581375, 32'd65025, 32'd255, 32'd1};

  // floor(2^32 / 255^i) for i = 1..3, used as reciprocals for the quotient estimate; index 0 holds 0
  localparam logic [3:0][24:0] RECIP = {25'd259, 25'd66051, 25'd16843009, 25'd0};

  localparam logic [31:0] POW255_4  = 32'd4228250625;
  localparam logic [8:0]  DIGIT_CAP = 9'd254;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // one chunk travelling down the digit pipeline
  typedef struct packed {
    logic        valid;
    logic        action;
    logic        ovf;
    logic [31:0] rem;
    logic [23:0] acc;
    logic [31:0] dec_val;
  } lane_t;

endpackage

// ----- sv/b255c_digit.sv -----
// one base-255 digit extraction, four register stages
module b255c_digit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          divisor,
  input  logic [24:0]          recip,
  input  b255c_pkg::lane_t     lane_in,
  output b255c_pkg::lane_t     lane_out
);

  b255c_pkg::lane_t l1;
  b255c_pkg::lane_t l2;
  b255c_pkg::lane_t l3;
  b255c_pkg::lane_t lane_next;
  logic [8:0]       est1;
  logic [8:0]       est2;
  logic [31:0]      prod2;
  logic [8:0]       q3;
  logic [31:0]      r3;

  logic [56:0]      est_prod;
  logic [40:0]      qd_prod;
  logic [31:0]      diff;
  logic             ge;

  // quotient estimate, low by at most one
  assign est_prod = 57'(lane_in.rem) * 57'(recip);
  assign qd_prod  = 41'(est1) * 41'(divisor);

  // correction by one step
  assign diff = l2.rem - prod2;
  assign ge   = (diff >= divisor);

  // digit cap at the exact boundary
  always_comb begin
    lane_next = l3;
    if (q3 > b255c_pkg::DIGIT_CAP) begin
      lane_next.acc = {l3.acc[15:0], b255c_pkg::DIGIT_CAP[7:0]};
      lane_next.rem = r3 + divisor;
    end else begin
      lane_next.acc = {l3.acc[15:0], q3[7:0]};
      lane_next.rem = r3;
    end
  end

  always_ff @(posedge clk) begin
    l1       <= lane_in;
    est1     <= est_prod[40:32];
    l2       <= l1;
    est2     <= est1;
    prod2    <= qd_prod[31:0];
    l3       <= l2;
    q3       <= est2 + 9'(ge);
    r3       <= ge ? (diff - divisor) : diff;
    lane_out <= lane_next;
    if (rst) begin
      l1.valid       <= 1'b0;
      l2.valid       <= 1'b0;
      l3.valid       <= 1'b0;
      lane_out.valid <= 1'b0;
    end
  end

endmodule

// ----- sv/base255_chunk_codec_top.sv -----
// top level of the base-255 chunk codec
// converts one 4-byte chunk per request between base 256 and base 255. a request
// is taken at every clock edge where start is high; busy is always low, so a new
// chunk may follow in every cycle. the result shows on result_word and
// overflow_out for exactly one cycle, marked by done, after the request has
// passed an input register, two stages for the overflow check and the decode
// sum, three digit units of four stages each (reciprocal multiply,
// back-multiply, one-step correction, digit cap) and an output register. the
// receiver cannot stall, and results leave in request order
module base255_chunk_codec_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] data_word,
  input  logic        overflow_in,
  output logic        done,
  output logic [31:0] result_word,
  output logic        overflow_out
);

  // input register
  logic        s0_valid;
  logic        s0_action;
  logic [31:0] s0_word;
  logic        s0_ovf_in;

  // overflow check and decode partial products
  logic        s1_valid;
  logic        s1_action;
  logic        s1_ovf;
  logic [31:0] s1_rem;
  logic [7:0]  s1_d0;
  logic [15:0] s1_p1;
  logic [23:0] s1_p2;
  logic [31:0] s1_p3;
  logic        s1_ovf_in;

  // decode partial sums
  logic        s2_valid;
  logic        s2_action;
  logic        s2_ovf;
  logic [31:0] s2_rem;
  logic [31:0] s2_sa;
  logic [31:0] s2_sb;

  logic                   enc_ovf;
  b255c_pkg::lane_t [3:0] chain;
  b255c_pkg::lane_t       fin;

  // the pipeline never holds off a request
  assign busy = 1'b0;

  // value above 255^4 has 255^4 taken off
  assign enc_ovf = (s0_word > b255c_pkg::POW255_4);

  always_ff @(posedge clk) begin
    s0_valid  <= start;
    s0_action <= action;
    s0_word   <= data_word;
    s0_ovf_in <= overflow_in;

    s1_valid  <= s0_valid;
    s1_action <= s0_action;
    s1_ovf    <= enc_ovf;
    s1_rem    <= enc_ovf ? (s0_word - b255c_pkg::POW255_4) : s0_word;
    s1_d0     <= s0_word[31:24];
    s1_p1     <= 16'(s0_word[23:16]) * b255c_pkg::POW255[1][15:0];
    s1_p2     <= 24'(s0_word[15:8]) * b255c_pkg::POW255[2][23:0];
    s1_p3     <= 32'(s0_word[7:0]) * b255c_pkg::POW255[3];
    s1_ovf_in <= s0_ovf_in;

    s2_valid  <= s1_valid;
    s2_action <= s1_action;
    s2_ovf    <= s1_ovf;
    s2_rem    <= s1_rem;
    s2_sa     <= s1_p3 + 32'(s1_p2);
    // sum wraps to 32 bits on purpose
    s2_sb     <= 32'(s1_p1) + 32'(s1_d0) + (s1_ovf_in ? b255c_pkg::POW255_4 : 32'd0);

    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end
  end

  // lane entering the digit units carries the finished decode value alongside
  always_comb begin
    chain[0].valid   = s2_valid;
    chain[0].action  = s2_action;
    chain[0].ovf     = s2_ovf;
    chain[0].rem     = s2_rem;
    chain[0].acc     = 24'd0;
    chain[0].dec_val = s2_sa + s2_sb;
  end

  // digits 3, 2 and 1 in turn; what remains is digit 0
  for (genvar g = 0; g < 3; g++) begin : g_digit
    b255c_digit u_digit (
      .clk      (clk),
      .rst      (rst),
      .divisor  (b255c_pkg::POW255[3-g]),
      .recip    (b255c_pkg::RECIP[3-g]),
      .lane_in  (chain[g]),
      .lane_out (chain[g+1])
    );
  end

  assign fin = chain[3];

  // output register, acc holds digits 3, 2, 1 from high to low
  always_ff @(posedge clk) begin
    done <= fin.valid;
    if (fin.action == b255c_pkg::ACT_DECODE) begin
      result_word  <= fin.dec_val;
      overflow_out <= 1'b0;
    end else begin
      result_word  <= {fin.rem[7:0], fin.acc[7:0], fin.acc[15:8], fin.acc[23:16]};
      overflow_out <= fin.ovf;
    end
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule
